### rtl/nrpa_pkg.sv
`default_nettype none
package nrpa_pkg;

    localparam int SECTIONS_DEF    = 4096;
    localparam int MAX_NESTING_DEF = 16;

    localparam logic [1:0] FUNC_OPEN  = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_BADSEC = 2'd3;

    typedef struct packed {
        logic [63:0] hits;
        logic [63:0] incl;
        logic [63:0] excl;
        logic [63:0] bytes;
        logic [63:0] faults;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OPEN_RD,
        ST_OPEN_WR,
        ST_CLS_RD,
        ST_CLS_WR,
        ST_PAR_RD,
        ST_PAR_WR,
        ST_READ_RD,
        ST_READ_OUT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RD_SEC,
        RD_TOP,
        RD_PAR
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_TOP,
        WR_PAR
    } wr_sel_t;

    typedef enum logic [2:0] {
        OUT_ZERO,
        OUT_RAM,
        OUT_CLS,
        OUT_PAR,
        OUT_SAVED
    } out_sel_t;

    typedef struct packed {
        logic     latch;
        logic     clear_wr;
        logic     we;
        wr_sel_t  wr_sel;
        rd_sel_t  rd_sel;
        logic     push;
        logic     pop;
        logic     cap_elapsed;
        logic     save_upd;
        logic     emit;
        out_sel_t out_sel;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic sec_bad;
        logic sec_oob;
        logic full;
        logic empty;
        logic has_parent;
        logic par_same;
        logic clear_last;
    } stat_t;

endpackage
`default_nettype wire

### rtl/nested_region_profile_accumulator_core.sv
// Sequence: an open reads its entry, then pushes; a close reads and writes the popped entry,
//   and if nested also reads and writes the parent; a read reads and outputs; flagged items emit.
// A new item is taken only after the table RAM read-modify-write sequence of the last one ends;
//   busy is high while an item is in flight.
// Reset: after rst_n rises the block clears the tables for SECTIONS cycles with busy high.
// done is a one-cycle strobe; the receiver cannot stall.
`default_nettype none
module nested_region_profile_accumulator_core #(
    parameter int SECTIONS    = nrpa_pkg::SECTIONS_DEF,
    parameter int MAX_NESTING = nrpa_pkg::MAX_NESTING_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [11:0] section,
    input  wire logic [63:0] timestamp,
    input  wire logic [63:0] fault_count,
    input  wire logic [63:0] byte_count,
    output logic             done,
    output logic [1:0]       status,
    output logic [63:0]      hits,
    output logic [63:0]      inclusive_ticks,
    output logic [63:0]      exclusive_ticks,
    output logic [63:0]      total_bytes,
    output logic [63:0]      total_faults,
    output logic [4:0]       open_depth
);
    // Controller sequences the table RAM: one read per entry touched, and for a close one write after it.
    // A close touches the popped entry, then its parent; since the parent read comes in the
    // cycle after the entry write, a recursive parent sees the already updated entry.
    nrpa_pkg::cmd_t  cmd;
    nrpa_pkg::stat_t stat;

    nrpa_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .func (func),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy)
    );

    // Datapath: register stack of open regions (each entry also holds its parent's
    // section), the counter table RAM, and the registered result.
    nrpa_datapath #(
        .SECTIONS   (SECTIONS),
        .MAX_NESTING(MAX_NESTING)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .section        (section),
        .timestamp      (timestamp),
        .fault_count    (fault_count),
        .byte_count     (byte_count),
        .done           (done),
        .status         (status),
        .hits           (hits),
        .inclusive_ticks(inclusive_ticks),
        .exclusive_ticks(exclusive_ticks),
        .total_bytes    (total_bytes),
        .total_faults   (total_faults),
        .open_depth     (open_depth)
    );
endmodule
`default_nettype wire

### rtl/nrpa_ram.sv
`default_nettype none
module nrpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### rtl/nrpa_ctrl.sv
`default_nettype none
module nrpa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     func,
    input  wire nrpa_pkg::stat_t stat,
    output nrpa_pkg::cmd_t      cmd,
    output logic                busy
);
    nrpa_pkg::state_t state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrpa_pkg::ST_CLEAR;
            code_reg  <= nrpa_pkg::STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cmd             = '0;
        cmd.wr_sel      = nrpa_pkg::WR_CLEAR;
        cmd.rd_sel      = nrpa_pkg::RD_SEC;
        cmd.out_sel     = nrpa_pkg::OUT_ZERO;
        cmd.status      = nrpa_pkg::STATUS_OK;
        busy            = 1'b1;
        case (state_reg)
            nrpa_pkg::ST_CLEAR:
            begin
                cmd.we       = 1'b1;
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = nrpa_pkg::ST_IDLE;
                end
            end
            nrpa_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
                if (start)
                begin
                    code_next  = nrpa_pkg::STATUS_OK;
                    state_next = nrpa_pkg::ST_EMIT;
                    case (func)
                        nrpa_pkg::FUNC_OPEN:
                        begin
                            if (stat.sec_bad)
                            begin
                                code_next = nrpa_pkg::STATUS_BADSEC;
                            end
                            else if (stat.full)
                            begin
                                code_next = nrpa_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                state_next = nrpa_pkg::ST_OPEN_RD;
                            end
                        end
                        nrpa_pkg::FUNC_CLOSE:
                        begin
                            if (stat.empty)
                            begin
                                code_next = nrpa_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = nrpa_pkg::ST_CLS_RD;
                            end
                        end
                        nrpa_pkg::FUNC_READ:
                        begin
                            if (!stat.sec_oob)
                            begin
                                state_next = nrpa_pkg::ST_READ_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            nrpa_pkg::ST_OPEN_RD:
            begin
                cmd.rd_sel = nrpa_pkg::RD_SEC;
                state_next = nrpa_pkg::ST_OPEN_WR;
            end
            nrpa_pkg::ST_OPEN_WR:
            begin
                cmd.push   = 1'b1;
                cmd.emit   = 1'b1;
                state_next = nrpa_pkg::ST_IDLE;
            end
            nrpa_pkg::ST_CLS_RD:
            begin
                cmd.rd_sel      = nrpa_pkg::RD_TOP;
                cmd.cap_elapsed = 1'b1;
                state_next      = nrpa_pkg::ST_CLS_WR;
            end
            nrpa_pkg::ST_CLS_WR:
            begin
                cmd.we       = 1'b1;
                cmd.wr_sel   = nrpa_pkg::WR_TOP;
                cmd.save_upd = 1'b1;
                if (stat.has_parent)
                begin
                    state_next = nrpa_pkg::ST_PAR_RD;
                end
                else
                begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = nrpa_pkg::OUT_CLS;
                    cmd.pop     = 1'b1;
                    state_next  = nrpa_pkg::ST_IDLE;
                end
            end
            nrpa_pkg::ST_PAR_RD:
            begin
                cmd.rd_sel = nrpa_pkg::RD_PAR;
                state_next = nrpa_pkg::ST_PAR_WR;
            end
            nrpa_pkg::ST_PAR_WR:
            begin
                cmd.we      = 1'b1;
                cmd.wr_sel  = nrpa_pkg::WR_PAR;
                cmd.emit    = 1'b1;
                cmd.out_sel = stat.par_same ? nrpa_pkg::OUT_PAR : nrpa_pkg::OUT_SAVED;
                cmd.pop     = 1'b1;
                state_next  = nrpa_pkg::ST_IDLE;
            end
            nrpa_pkg::ST_READ_RD:
            begin
                cmd.rd_sel = nrpa_pkg::RD_SEC;
                state_next = nrpa_pkg::ST_READ_OUT;
            end
            nrpa_pkg::ST_READ_OUT:
            begin
                cmd.emit    = 1'b1;
                cmd.out_sel = nrpa_pkg::OUT_RAM;
                state_next  = nrpa_pkg::ST_IDLE;
            end
            nrpa_pkg::ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.status = code_reg;
                state_next = nrpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nrpa_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/nrpa_datapath.sv
`default_nettype none
module nrpa_datapath #(
    parameter int SECTIONS    = nrpa_pkg::SECTIONS_DEF,
    parameter int MAX_NESTING = nrpa_pkg::MAX_NESTING_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire nrpa_pkg::cmd_t  cmd,
    output nrpa_pkg::stat_t      stat,
    input  wire logic [11:0]     section,
    input  wire logic [63:0]     timestamp,
    input  wire logic [63:0]     fault_count,
    input  wire logic [63:0]     byte_count,
    output logic                 done,
    output logic [1:0]           status,
    output logic [63:0]          hits,
    output logic [63:0]          inclusive_ticks,
    output logic [63:0]          exclusive_ticks,
    output logic [63:0]          total_bytes,
    output logic [63:0]          total_faults,
    output logic [4:0]           open_depth
);
    localparam int AW = $clog2(SECTIONS);
    localparam int PW = $clog2(MAX_NESTING + 1);
    localparam int SW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int EW = $bits(nrpa_pkg::entry_t);

    logic [11:0] sec_reg;
    logic [63:0] ts_reg, fc_reg, bc_reg;

    logic [AW-1:0] stk_sec  [MAX_NESTING];
    logic [AW-1:0] stk_par  [MAX_NESTING];
    logic [63:0]   stk_time [MAX_NESTING];
    logic [63:0]   stk_flt  [MAX_NESTING];
    logic [63:0]   stk_byt  [MAX_NESTING];
    logic [63:0]   stk_incl [MAX_NESTING];

    logic [PW-1:0] sp_reg, sp_next, sp_m1;
    logic [AW-1:0] top_sec_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [SW-1:0] top_idx, push_idx;

    logic [63:0] elapsed_reg, dflt_reg;
    nrpa_pkg::entry_t upd_reg, cls_upd, par_upd, rdata, wdata, out_ent;
    logic [EW-1:0] rdata_raw;
    logic [AW-1:0] raddr, waddr;

    logic          done_reg;
    logic [1:0]    status_reg;
    nrpa_pkg::entry_t out_reg;
    logic [4:0]    depth_reg;

    assign sp_m1    = sp_reg - PW'(1);
    assign top_idx  = sp_m1[SW-1:0];
    assign push_idx = sp_reg[SW-1:0];

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.push)
        begin
            sp_next = sp_reg + PW'(1);
        end
        else if (cmd.pop)
        begin
            sp_next = sp_m1;
        end
    end

    assign stat.sec_oob    = 32'(section) >= 32'(SECTIONS);
    assign stat.sec_bad    = (section == 12'd0) || stat.sec_oob;
    assign stat.full       = sp_reg == PW'(MAX_NESTING);
    assign stat.empty      = sp_reg == '0;
    assign stat.has_parent = stk_par[top_idx] != '0;
    assign stat.par_same   = stk_par[top_idx] == stk_sec[top_idx];
    assign stat.clear_last = clr_cnt_reg == AW'(SECTIONS - 1);

    assign rdata = nrpa_pkg::entry_t'(rdata_raw);

    always_comb
    begin
        cls_upd.hits   = rdata.hits + 64'd1;
        cls_upd.incl   = stk_incl[top_idx] + elapsed_reg;
        cls_upd.excl   = rdata.excl + elapsed_reg;
        cls_upd.bytes  = rdata.bytes + stk_byt[top_idx];
        cls_upd.faults = rdata.faults + dflt_reg;
        par_upd        = rdata;
        par_upd.excl   = rdata.excl - elapsed_reg;
        par_upd.faults = rdata.faults - dflt_reg;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            nrpa_pkg::RD_TOP: raddr = stk_sec[top_idx];
            nrpa_pkg::RD_PAR: raddr = stk_par[top_idx];
            default:          raddr = AW'(sec_reg);
        endcase
        case (cmd.wr_sel)
            nrpa_pkg::WR_TOP:
            begin
                waddr = stk_sec[top_idx];
                wdata = cls_upd;
            end
            nrpa_pkg::WR_PAR:
            begin
                waddr = stk_par[top_idx];
                wdata = par_upd;
            end
            default:
            begin
                waddr = clr_cnt_reg;
                wdata = '0;
            end
        endcase
        case (cmd.out_sel)
            nrpa_pkg::OUT_RAM:   out_ent = rdata;
            nrpa_pkg::OUT_CLS:   out_ent = cls_upd;
            nrpa_pkg::OUT_PAR:   out_ent = par_upd;
            nrpa_pkg::OUT_SAVED: out_ent = upd_reg;
            default:             out_ent = '0;
        endcase
    end

    nrpa_ram #(
        .WIDTH(EW),
        .DEPTH(SECTIONS)
    ) u_table (
        .clk  (clk),
        .we   (cmd.we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            top_sec_reg <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            sp_reg   <= sp_next;
            done_reg <= cmd.emit;
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.push)
            begin
                top_sec_reg <= AW'(sec_reg);
            end
            else if (cmd.pop)
            begin
                top_sec_reg <= stk_par[top_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sec_reg <= section;
            ts_reg  <= timestamp;
            fc_reg  <= fault_count;
            bc_reg  <= byte_count;
        end
        if (cmd.push)
        begin
            stk_sec[push_idx]  <= AW'(sec_reg);
            stk_par[push_idx]  <= top_sec_reg;
            stk_time[push_idx] <= ts_reg;
            stk_flt[push_idx]  <= fc_reg;
            stk_byt[push_idx]  <= bc_reg;
            stk_incl[push_idx] <= rdata.incl;
        end
        if (cmd.cap_elapsed)
        begin
            elapsed_reg <= ts_reg - stk_time[top_idx];
            dflt_reg    <= fc_reg - stk_flt[top_idx];
        end
        if (cmd.save_upd)
        begin
            upd_reg <= cls_upd;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.status;
            out_reg    <= out_ent;
            depth_reg  <= 5'(sp_next);
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign hits            = out_reg.hits;
    assign inclusive_ticks = out_reg.incl;
    assign exclusive_ticks = out_reg.excl;
    assign total_bytes     = out_reg.bytes;
    assign total_faults    = out_reg.faults;
    assign open_depth      = depth_reg;
endmodule
`default_nettype wire

### rtl/nrpa_checker.sv
`default_nettype none
module nrpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [63:0] hits,
    input wire logic [63:0] total_bytes,
    input wire logic [4:0]  open_depth
);
    // every accepted transfer makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept without busy");

    // result strobe lands as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // flagged items carry no counters
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != nrpa_pkg::STATUS_OK) |-> (hits == 64'd0 && total_bytes == 64'd0))
        else $error("flagged result with counters");

    // close on empty stack leaves nothing open
    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == nrpa_pkg::STATUS_EMPTY) |-> open_depth == 5'd0)
        else $error("empty status with open regions");
endmodule

bind nested_region_profile_accumulator_core nrpa_checker u_nrpa_checker (.*);
`default_nettype wire
